FILE: design/epbs_pkg.sv
`default_nettype none
package epbs_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_PROFILE_LEN = 512;
	localparam int DEF_VALUE_BITS      = 9;

	// Template ROM sizes
	localparam int X_LO_SIZE = 24;
	localparam int X_HI_SIZE = 24;
	localparam int Y_LO_SIZE = 48;
	localparam int Y_HI_SIZE = 24;

	// Template index width and template value width (hundredths of 1.0)
	localparam int TIDX_W = 6;
	localparam int HUND_W = 7;

	// Upper template is wide (1.0) below this entry and from the tail entry on
	localparam int UPPER_WIDE_HEAD = 4;
	localparam int UPPER_WIDE_TAIL = 20;

	// Template values in hundredths
	localparam logic [HUND_W-1:0] HUND_FULL   = 7'd100;
	localparam logic [HUND_W-1:0] HUND_HALF   = 7'd50;
	localparam logic [HUND_W-1:0] HUND_START  = 7'd40;
	localparam logic [HUND_W-1:0] HUND_SHOULD = 7'd60;
	localparam logic [HUND_W-1:0] HUND_X_BODY = 7'd10;
	localparam logic [HUND_W-1:0] HUND_Y_BODY = 7'd5;
	localparam logic [HUND_W-1:0] HUND_ZERO   = 7'd0;

	// Quotient bits produced by the serial divider
	localparam int QUOT_BITS = 7;

	// Port widths fixed by the item format
	localparam int LEN_IN_W = 10;
	localparam int SCORE_W  = 7;
	localparam int PERCENT  = 100;

	// Upper template value, same for both axes
	function automatic logic [HUND_W-1:0] upper_hundredths(input logic [TIDX_W-1:0] idx);
		logic wide;
		wide = (idx < TIDX_W'(UPPER_WIDE_HEAD)) || (idx >= TIDX_W'(UPPER_WIDE_TAIL));
		return wide ? HUND_FULL : HUND_HALF;
	endfunction

	// Lower template value for column or row profile
	function automatic logic [HUND_W-1:0] lower_hundredths(input logic row,
			input logic [TIDX_W-1:0] idx);
		logic [TIDX_W-1:0] last;
		logic [HUND_W-1:0] val;
		last = row ? TIDX_W'(Y_LO_SIZE - 1) : TIDX_W'(X_LO_SIZE - 1);
		if (idx == '0)
			val = HUND_START;
		else if (idx == TIDX_W'(1))
			val = HUND_SHOULD;
		else if (idx == last - TIDX_W'(1))
			val = HUND_SHOULD;
		else if (idx >= last)
			val = HUND_ZERO;
		else
			val = row ? HUND_Y_BODY : HUND_X_BODY;
		return val;
	endfunction

endpackage
`default_nettype wire

FILE: design/epbs_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle; quotient saturates at all ones
module epbs_div #(
	parameter int DW = 17,
	parameter int LW = 10
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [DW-1:0]                  dividend,
	input  wire logic [LW-1:0]                  divisor,
	output logic                                busy,
	output logic [epbs_pkg::QUOT_BITS-1:0]      quotient
);

	localparam int QB    = epbs_pkg::QUOT_BITS;
	localparam int CNT_W = $clog2(QB);

	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dv_q;
	logic [QB-1:0]    quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             fits;

	assign fits     = rem_q >= dv_q;
	assign busy     = busy_q;
	assign quotient = quot_q;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QB - 1);
		end else if (busy_q) begin
			if (cnt_q == '0)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Remainder, shifting divisor and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dv_q   <= DW'(divisor) << (QB - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits)
				rem_q <= rem_q - dv_q;
			dv_q   <= dv_q >> 1;
			quot_q <= {quot_q[QB-2:0], fits};
		end
	end

endmodule
`default_nettype wire

FILE: design/epbs_band.sv
`default_nettype none
// Template lookup and strict band test of one scaled average
module epbs_band #(
	parameter int VALUE_BITS = epbs_pkg::DEF_VALUE_BITS
) (
	input  wire logic                                           row,
	input  wire logic [epbs_pkg::QUOT_BITS-1:0]                 q_lo,
	input  wire logic [epbs_pkg::QUOT_BITS-1:0]                 q_hi,
	input  wire logic [VALUE_BITS+epbs_pkg::HUND_W-1:0]         avg100,
	output logic                                                match
);

	localparam int AVG_W = VALUE_BITS + epbs_pkg::HUND_W;
	localparam int QB    = epbs_pkg::QUOT_BITS;
	localparam int TW    = epbs_pkg::TIDX_W;

	logic [TW-1:0]               lo_last;
	logic [TW-1:0]               hi_last;
	logic [TW-1:0]               lo_idx;
	logic [TW-1:0]               hi_idx;
	logic [epbs_pkg::HUND_W-1:0] lo_h;
	logic [epbs_pkg::HUND_W-1:0] hi_h;
	logic [AVG_W-1:0]            lo_sc;
	logic [AVG_W-1:0]            hi_sc;

	// Clamp indexes to the last ROM entry
	assign lo_last = row ? TW'(epbs_pkg::Y_LO_SIZE - 1) : TW'(epbs_pkg::X_LO_SIZE - 1);
	assign hi_last = row ? TW'(epbs_pkg::Y_HI_SIZE - 1) : TW'(epbs_pkg::X_HI_SIZE - 1);
	assign lo_idx  = (q_lo > QB'(lo_last)) ? lo_last : q_lo[TW-1:0];
	assign hi_idx  = (q_hi > QB'(hi_last)) ? hi_last : q_hi[TW-1:0];

	// Look up templates and scale to the average's fixed point
	assign lo_h  = epbs_pkg::lower_hundredths(row, lo_idx);
	assign hi_h  = epbs_pkg::upper_hundredths(hi_idx);
	assign lo_sc = AVG_W'(lo_h) << (VALUE_BITS - 1);
	assign hi_sc = AVG_W'(hi_h) << (VALUE_BITS - 1);

	assign match = (avg100 > lo_sc) && (avg100 < hi_sc);

endmodule
`default_nettype wire

FILE: design/edge_profile_band_score_unit.sv
`default_nettype none
// Profile band scorer: one average per transfer, a score on the last one.
// Items are taken only in idle: both dividers form the template indexes, one quotient
// bit per cycle, then an update step counts a match before the next item is taken.
// A last item then reuses divider A for the score division and loads the score before
// the next item is taken; the load waits while an earlier score is held and not taken.
// Reset (arst_n low, asynchronous) clears the counters and drops out_valid.
module edge_profile_band_score_unit #(
	parameter int MAX_PROFILE_LEN = epbs_pkg::DEF_MAX_PROFILE_LEN,
	parameter int VALUE_BITS      = epbs_pkg::DEF_VALUE_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [VALUE_BITS-1:0]             average_value,
	input  wire logic                              axis,
	input  wire logic [epbs_pkg::LEN_IN_W-1:0]     profile_length,
	input  wire logic                              last_item,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	output logic [epbs_pkg::SCORE_W-1:0]           score_percent,
	output logic                                   out_valid,
	input  wire logic                              out_ready
);

	localparam int PW     = $clog2(MAX_PROFILE_LEN);
	localparam int MW     = $clog2(MAX_PROFILE_LEN + 1);
	localparam int QB     = epbs_pkg::QUOT_BITS;
	localparam int DW     = MW + QB;
	localparam int LEN_CW = (MW > epbs_pkg::LEN_IN_W) ? MW : epbs_pkg::LEN_IN_W;
	localparam int AVG_W  = VALUE_BITS + epbs_pkg::HUND_W;
	localparam int SW     = epbs_pkg::SCORE_W;

	typedef enum logic [1:0] {S_IDLE, S_IDX, S_SCORE} state_t;

	state_t           state_q;
	logic [PW-1:0]    pos_q;
	logic [MW-1:0]    match_q;
	logic             out_valid_q;
	logic [MW-1:0]    len_q;
	logic [AVG_W-1:0] avg100_q;
	logic             row_q;
	logic             last_q;
	logic [SW-1:0]    score_q;

	logic             accept;
	logic [LEN_CW-1:0] len_wide;
	logic [MW-1:0]    len_clamp;
	logic [DW-1:0]    idx_lo_dvd;
	logic [DW-1:0]    idx_hi_dvd;
	logic [DW-1:0]    score_dvd;
	logic             band_match;
	logic [MW-1:0]    match_next;
	logic             idx_done;
	logic             start_a;
	logic [DW-1:0]    dividend_a;
	logic [MW-1:0]    divisor_a;
	logic             busy_a;
	logic             busy_b;
	logic [QB-1:0]    quot_a;
	logic [QB-1:0]    quot_b;
	logic [SW-1:0]    score_sat;
	logic             out_free;
	logic             score_load;

	assign in_ready      = (state_q == S_IDLE);
	assign accept        = in_valid && in_ready;
	assign out_valid     = out_valid_q;
	assign score_percent = score_q;
	assign out_free      = !out_valid_q || out_ready;

	// Clamp the profile length to 1..MAX_PROFILE_LEN
	always_comb begin
		len_wide = LEN_CW'(profile_length);
		if (len_wide == '0)
			len_clamp = MW'(1);
		else if (len_wide > LEN_CW'(MAX_PROFILE_LEN))
			len_clamp = MW'(MAX_PROFILE_LEN);
		else
			len_clamp = MW'(len_wide);
	end

	// Index dividends: position times (rom size - 1)
	assign idx_lo_dvd = axis ? DW'(pos_q) * DW'(epbs_pkg::Y_LO_SIZE - 1)
	                         : DW'(pos_q) * DW'(epbs_pkg::X_LO_SIZE - 1);
	assign idx_hi_dvd = axis ? DW'(pos_q) * DW'(epbs_pkg::Y_HI_SIZE - 1)
	                         : DW'(pos_q) * DW'(epbs_pkg::X_HI_SIZE - 1);

	// Match counter with saturation
	assign match_next = (band_match && (match_q < MW'(MAX_PROFILE_LEN)))
	                  ? match_q + MW'(1) : match_q;
	assign score_dvd  = DW'(match_next) * DW'(epbs_pkg::PERCENT);

	// Share divider A between the lower index and the score
	assign idx_done   = (state_q == S_IDX) && !busy_a && !busy_b;
	assign start_a    = accept || (idx_done && last_q);
	assign dividend_a = accept ? idx_lo_dvd : score_dvd;
	assign divisor_a  = accept ? len_clamp : len_q;

	assign score_sat = (quot_a > QB'(epbs_pkg::PERCENT)) ? SW'(epbs_pkg::PERCENT)
	                                                      : SW'(quot_a);

	// Load the score once the division is done and the output is free
	assign score_load = (state_q == S_SCORE) && !busy_a && out_free;

	epbs_div #(.DW(DW), .LW(MW)) u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_a),
		.dividend (dividend_a),
		.divisor  (divisor_a),
		.busy     (busy_a),
		.quotient (quot_a)
	);

	epbs_div #(.DW(DW), .LW(MW)) u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (idx_hi_dvd),
		.divisor  (len_clamp),
		.busy     (busy_b),
		.quotient (quot_b)
	);

	epbs_band #(.VALUE_BITS(VALUE_BITS)) u_band (
		.row    (row_q),
		.q_lo   (quot_a),
		.q_hi   (quot_b),
		.avg100 (avg100_q),
		.match  (band_match)
	);

	// Sequencer, counters, output valid and score
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			match_q     <= '0;
			out_valid_q <= 1'b0;
			score_q     <= '0;
		end else begin
			if (score_load) begin
				out_valid_q <= 1'b1;
				score_q     <= score_sat;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_IDX;
				end
				S_IDX: begin
					if (idx_done) begin
						if (last_q) begin
							pos_q   <= '0;
							match_q <= '0;
							state_q <= S_SCORE;
						end else begin
							match_q <= match_next;
							if (pos_q < PW'(MAX_PROFILE_LEN - 1))
								pos_q <= pos_q + PW'(1);
							state_q <= S_IDLE;
						end
					end
				end
				S_SCORE: begin
					if (score_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			avg100_q <= AVG_W'(average_value) * AVG_W'(epbs_pkg::PERCENT);
			row_q    <= axis;
			last_q   <= last_item;
			len_q    <= len_clamp;
		end
	end

endmodule
`default_nettype wire
